FILE: hdl/pslcp_pkg.sv
package pslcp_pkg;

  localparam int WORD_W   = 64;
  localparam int IN_WORDS = 4;
  localparam int WORDS    = 4;
  localparam int LEN_W    = 8;
  localparam int MAXLEN   = WORDS * 32;
  localparam int SLEN_W   = $clog2(MAXLEN + 1);
  localparam int BITS_W   = $clog2(WORDS * WORD_W + 1);
  localparam int IDX_W    = $clog2(WORDS * WORD_W);
  localparam int LZ_W     = $clog2(WORD_W + 1);
  localparam int ORDER_W  = 2;
  localparam int COMMON_W = 9;
  localparam int CODE_W   = 2;

  localparam logic signed [ORDER_W-1:0] ORDER_LESS    = -2'sd1;
  localparam logic signed [ORDER_W-1:0] ORDER_EQUAL   = 2'sd0;
  localparam logic signed [ORDER_W-1:0] ORDER_GREATER = 2'sd1;

  localparam logic [CODE_W-1:0] CODE_END    = 2'd0;
  localparam logic [CODE_W-1:0] CODE_NEXT0  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NEXT1  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DIFFER = 2'd3;

  typedef struct packed {
    logic            active;
    logic            diff;
    logic            gt;
    logic [LZ_W-1:0] lz;
  } lane_res_t;

  typedef struct packed {
    logic signed [ORDER_W-1:0] order;
    logic [COMMON_W-1:0]       common_bits;
    logic [CODE_W-1:0]         next_code;
  } result_t;

endpackage

FILE: hdl/pslcp_pair_if.sv
interface pslcp_pair_if import pslcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seq1_word0;
  logic [WORD_W-1:0] seq1_word1;
  logic [WORD_W-1:0] seq1_word2;
  logic [WORD_W-1:0] seq1_word3;
  logic [WORD_W-1:0] seq2_word0;
  logic [WORD_W-1:0] seq2_word1;
  logic [WORD_W-1:0] seq2_word2;
  logic [WORD_W-1:0] seq2_word3;
  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  second_length;

  modport source (
    output valid, seq1_word0, seq1_word1, seq1_word2, seq1_word3,
           seq2_word0, seq2_word1, seq2_word2, seq2_word3,
           first_length, second_length,
    input  ready
  );

  modport sink (
    input  valid, seq1_word0, seq1_word1, seq1_word2, seq1_word3,
           seq2_word0, seq2_word1, seq2_word2, seq2_word3,
           first_length, second_length,
    output ready
  );
endinterface

FILE: hdl/pslcp_result_if.sv
interface pslcp_result_if import pslcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ORDER_W-1:0] order;
  logic [COMMON_W-1:0]       common_bits;
  logic [CODE_W-1:0]         next_code;

  modport source (
    output valid, order, common_bits, next_code,
    input  ready
  );

  modport sink (
    input  valid, order, common_bits, next_code,
    output ready
  );
endinterface

FILE: hdl/pslcp_lane.sv
module pslcp_lane import pslcp_pkg::*; (
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic              active,
  output lane_res_t         res
);

  localparam int BYTES = WORD_W / 8;

  logic [WORD_W-1:0] x;
  logic [2:0]        byte_lz [BYTES];
  logic [BYTES-1:0]  byte_nz;
  logic [LZ_W-1:0]   lz;

  assign x = a ^ b;

  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      byte_lz[i] = 3'd0;
      byte_nz[i] = |x[WORD_W-1-8*i -: 8];
      for (int k = 0; k < 8; k++) begin
        if (x[WORD_W-8-8*i+k]) begin
          byte_lz[i] = 3'(7 - k);
        end
      end
    end
  end

  always_comb begin
    lz = LZ_W'(WORD_W);
    for (int i = BYTES - 1; i >= 0; i--) begin
      if (byte_nz[i]) begin
        lz = LZ_W'(8 * i) + LZ_W'(byte_lz[i]);
      end
    end
  end

  assign res.active = active;
  assign res.diff   = |x;
  assign res.gt     = a > b;
  assign res.lz     = lz;

endmodule

FILE: hdl/pslcp_merge.sv
module pslcp_merge import pslcp_pkg::*; (
  input  lane_res_t [WORDS-1:0] lanes,
  input  logic [SLEN_W-1:0]     len1,
  input  logic [SLEN_W-1:0]     len2,
  input  logic [BITS_W-1:0]     min_bits,
  input  logic                  next_bit,
  output result_t               res
);

  logic                      found;
  logic signed [ORDER_W-1:0] ord;
  logic [BITS_W-1:0]         lcp;
  logic [BITS_W-1:0]         lcp_cap;
  logic [CODE_W-1:0]         code;

  always_comb begin
    found = 1'b0;
    ord   = ORDER_EQUAL;
    lcp   = '0;
    for (int w = 0; w < WORDS; w++) begin
      if (!found && lanes[w].active) begin
        if (lanes[w].diff) begin
          found = 1'b1;
          ord   = lanes[w].gt ? ORDER_GREATER : ORDER_LESS;
          lcp   = BITS_W'(w * WORD_W) + BITS_W'(lanes[w].lz);
        end else begin
          lcp = BITS_W'((w + 1) * WORD_W);
        end
      end
    end
    if (ord == ORDER_EQUAL) begin
      if (len1 > len2) begin
        ord = ORDER_GREATER;
      end else if (len1 < len2) begin
        ord = ORDER_LESS;
      end
    end
  end

  always_comb begin
    lcp_cap = (lcp > min_bits) ? min_bits : lcp;
    if (lcp_cap < min_bits) begin
      code = CODE_DIFFER;
    end else if (len1 < len2) begin
      code = next_bit ? CODE_NEXT1 : CODE_NEXT0;
    end else begin
      code = CODE_END;
    end
  end

  assign res.order       = ord;
  assign res.common_bits = COMMON_W'(lcp_cap);
  assign res.next_code   = code;

endmodule

FILE: hdl/packed_sequence_lcp_compare_unit.sv
// Compares two sequences of 2-bit characters, each packed MSB first into four
// 64-bit words, and returns their order, the common prefix length in bits
// (capped at twice the shorter length) and a code for what follows it.
// Lengths above 128 saturate. One pair is taken every cycle while results are
// taken as they are offered. An accepted pair first fills the register stage
// that holds the four word lanes (compare and leading-zero count), then the one
// that holds the merged result, from which its result is offered. The output
// register lets a new pair in while a result waits to be taken.
module packed_sequence_lcp_compare_unit import pslcp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  pslcp_pair_if.sink     pair,
  pslcp_result_if.source result
);

  logic [WORD_W-1:0]       in_a [IN_WORDS];
  logic [WORD_W-1:0]       in_b [IN_WORDS];
  logic [WORD_W-1:0]       wa   [WORDS];
  logic [WORD_W-1:0]       wb   [WORDS];
  logic [WORDS*WORD_W-1:0] seq2_flat;
  logic [SLEN_W-1:0]       len1_sat;
  logic [SLEN_W-1:0]       len2_sat;
  logic [SLEN_W-1:0]       min_len;
  logic [BITS_W-1:0]       min_bits;
  logic [IDX_W-1:0]        bit_idx;
  logic                    next_bit;
  lane_res_t [WORDS-1:0]   lane_res;

  logic                    s1_valid;
  lane_res_t [WORDS-1:0]   s1_lanes;
  logic [SLEN_W-1:0]       s1_len1;
  logic [SLEN_W-1:0]       s1_len2;
  logic [BITS_W-1:0]       s1_min_bits;
  logic                    s1_next_bit;
  logic                    s1_advance;

  result_t                 merged;
  logic                    out_valid;
  result_t                 out_res;

  assign in_a[0] = pair.seq1_word0;
  assign in_a[1] = pair.seq1_word1;
  assign in_a[2] = pair.seq1_word2;
  assign in_a[3] = pair.seq1_word3;
  assign in_b[0] = pair.seq2_word0;
  assign in_b[1] = pair.seq2_word1;
  assign in_b[2] = pair.seq2_word2;
  assign in_b[3] = pair.seq2_word3;

  always_comb begin
    len1_sat = (int'(pair.first_length) > MAXLEN) ? SLEN_W'(MAXLEN)
                                                  : SLEN_W'(pair.first_length);
    len2_sat = (int'(pair.second_length) > MAXLEN) ? SLEN_W'(MAXLEN)
                                                   : SLEN_W'(pair.second_length);
    min_len  = (len1_sat < len2_sat) ? len1_sat : len2_sat;
    min_bits = BITS_W'(min_len) << 1;
  end

  for (genvar w = 0; w < WORDS; w++) begin : g_lane
    localparam int LaneBase = w * WORD_W;
    if (w < IN_WORDS) begin : g_word
      assign wa[w] = in_a[w];
      assign wb[w] = in_b[w];
    end else begin : g_zero
      assign wa[w] = '0;
      assign wb[w] = '0;
    end
    assign seq2_flat[(WORDS-1-w)*WORD_W +: WORD_W] = wb[w];

    pslcp_lane u_lane (
      .a      (wa[w]),
      .b      (wb[w]),
      .active (BITS_W'(LaneBase) < min_bits),
      .res    (lane_res[w])
    );
  end

  assign bit_idx  = IDX_W'(WORDS * WORD_W - 1) - min_bits[IDX_W-1:0];
  assign next_bit = seq2_flat[bit_idx];

  assign s1_advance = !out_valid || result.ready;
  assign pair.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pair.ready) begin
      s1_valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair.valid && pair.ready) begin
      s1_lanes    <= lane_res;
      s1_len1     <= len1_sat;
      s1_len2     <= len2_sat;
      s1_min_bits <= min_bits;
      s1_next_bit <= next_bit;
    end
  end

  pslcp_merge u_merge (
    .lanes    (s1_lanes),
    .len1     (s1_len1),
    .len2     (s1_len2),
    .min_bits (s1_min_bits),
    .next_bit (s1_next_bit),
    .res      (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      out_res <= merged;
    end
  end

  assign result.valid       = out_valid;
  assign result.order       = out_res.order;
  assign result.common_bits = out_res.common_bits;
  assign result.next_code   = out_res.next_code;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pair.valid && pair.ready |=> s1_valid)
    else $error("accepted pair did not reach lane stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_min_bits) && $stable(s1_len1))
    else $error("lane stage changed while stalled");

  a_differ_has_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.next_code == CODE_DIFFER |-> out_res.order != ORDER_EQUAL)
    else $error("differing prefix with equal order");

  a_end_prefix_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.next_code != CODE_DIFFER |-> !out_res.common_bits[0])
    else $error("full prefix not a whole number of characters");

endmodule

FILE: verif/pslcp_result_check.sv
module pslcp_result_check import pslcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pslcp_pair_if       pair,
  pslcp_result_if     result,
  output int unsigned fail_count,
  output int unsigned pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t expected_q[$];

  function automatic result_t predict_lcp(
    input logic [IN_WORDS-1:0][WORD_W-1:0] s1,
    input logic [IN_WORDS-1:0][WORD_W-1:0] s2,
    input logic [LEN_W-1:0]                l1,
    input logic [LEN_W-1:0]                l2
  );
    int unsigned               len1;
    int unsigned               len2;
    int unsigned               span_bits;
    int unsigned               span_words;
    int unsigned               common;
    int unsigned               lz;
    int unsigned               next_word;
    logic [WORD_W-1:0]         wa;
    logic [WORD_W-1:0]         wb;
    logic [WORD_W-1:0]         x;
    logic [WORD_W-1:0]         tail_word;
    logic                      found;
    logic signed [ORDER_W-1:0] ord;
    logic [CODE_W-1:0]         code;
    result_t                   r;
    len1 = (l1 > MAXLEN) ? MAXLEN : l1;
    len2 = (l2 > MAXLEN) ? MAXLEN : l2;
    span_bits = 2 * ((len1 < len2) ? len1 : len2);
    span_words = (span_bits + WORD_W - 1) / WORD_W;
    ord = ORDER_EQUAL;
    found = 1'b0;
    common = 0;
    for (int w = 0; w < span_words; w++) begin
      wa = (w < IN_WORDS) ? s1[w] : '0;
      wb = (w < IN_WORDS) ? s2[w] : '0;
      if (!found) begin
        if (wa != wb) begin
          ord = (wa > wb) ? ORDER_GREATER : ORDER_LESS;
          x = wa ^ wb;
          lz = 0;
          while (lz < WORD_W && !x[WORD_W-1-lz]) lz++;
          common += lz;
          found = 1'b1;
        end else begin
          common += WORD_W;
        end
      end
    end
    if (ord == ORDER_EQUAL)
      ord = (len1 > len2) ? ORDER_GREATER : ((len1 < len2) ? ORDER_LESS : ORDER_EQUAL);
    if (common > span_bits) common = span_bits;
    if (common < span_bits) begin
      code = CODE_DIFFER;
    end else if (len1 < len2) begin
      next_word = span_bits / WORD_W;
      tail_word = (next_word < IN_WORDS) ? s2[next_word] : '0;
      code = tail_word[WORD_W-1-(span_bits % WORD_W)] ? CODE_NEXT1 : CODE_NEXT0;
    end else begin
      code = CODE_END;
    end
    r.order = ord;
    r.common_bits = common[COMMON_W-1:0];
    r.next_code = code;
    return r;
  endfunction

  always @(posedge clk) begin : observe
    result_t got;
    result_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.order = result.order;
        got.common_bits = result.common_bits;
        got.next_code = result.next_code;
        if (expected_q.size() == 0) begin
          $error("result item with no pair outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.order !== want.order) begin
            $error("order: expected %0d, actual %0d", want.order, got.order);
            fail_count++;
          end
          if (got.common_bits !== want.common_bits) begin
            $error("common_bits: expected %0d, actual %0d", want.common_bits, got.common_bits);
            fail_count++;
          end
          if (got.next_code !== want.next_code) begin
            $error("next_code: expected %0d, actual %0d", want.next_code, got.next_code);
            fail_count++;
          end
        end
      end
      if (pair.valid && pair.ready)
        expected_q.push_back(predict_lcp(
          {pair.seq1_word3, pair.seq1_word2, pair.seq1_word1, pair.seq1_word0},
          {pair.seq2_word3, pair.seq2_word2, pair.seq2_word1, pair.seq2_word0},
          pair.first_length, pair.second_length));
    end
    pending_results <= expected_q.size();
  end
endmodule

FILE: verif/packed_sequence_lcp_compare_unit_tb.sv
module packed_sequence_lcp_compare_unit_tb import pslcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;

  pslcp_pair_if   pair_ch ();
  pslcp_result_if result_ch ();

  packed_sequence_lcp_compare_unit dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch)
  );

  pslcp_result_check result_check (
    .clk             (clk),
    .rst             (rst),
    .pair            (pair_ch),
    .result          (result_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [255:0] rand_seq();
    logic [255:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r = {r[223:0], 32'($urandom())};
    return r;
  endfunction

  function automatic logic [255:0] bit_at(input int unsigned p);
    return 256'b1 << (255 - p);
  endfunction

  task automatic offer_pair(input logic [255:0] s1, input logic [255:0] s2,
                            input logic [7:0] l1, input logic [7:0] l2);
    pair_ch.valid         <= 1'b1;
    pair_ch.seq1_word0    <= s1[255:192];
    pair_ch.seq1_word1    <= s1[191:128];
    pair_ch.seq1_word2    <= s1[127:64];
    pair_ch.seq1_word3    <= s1[63:0];
    pair_ch.seq2_word0    <= s2[255:192];
    pair_ch.seq2_word1    <= s2[191:128];
    pair_ch.seq2_word2    <= s2[127:64];
    pair_ch.seq2_word3    <= s2[63:0];
    pair_ch.first_length  <= l1;
    pair_ch.second_length <= l2;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int unsigned odds);
    if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, odds) == 0) begin
      pair_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic make_pair(output logic [255:0] s1, output logic [255:0] s2,
                           output logic [7:0] l1, output logic [7:0] l2);
    int unsigned p;
    logic [255:0] flip;
    p = $urandom_range(0, 255);
    s1 = rand_seq();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        flip = bit_at(p);
        if ($urandom_range(0, 1)) flip = flip | (rand_seq() >> (p + 1));
        s2 = s1 ^ flip;
      end
      6: s2 = s1;
      7: s2 = rand_seq();
      default: begin
        s1 = {{64{1'($urandom_range(0, 1))}}, {64{1'($urandom_range(0, 1))}},
              {64{1'($urandom_range(0, 1))}}, {64{1'($urandom_range(0, 1))}}};
        s2 = $urandom_range(0, 1) ? s1 : ~s1;
      end
    endcase
    case ($urandom_range(0, 5))
      0: begin
        l1 = 8'($urandom_range(0, 128));
        l2 = l1;
      end
      1, 2: begin
        l1 = 8'($urandom_range(0, 128));
        l2 = 8'($urandom_range(0, 128));
      end
      3: begin
        l1 = 8'($urandom_range(0, 255));
        l2 = 8'($urandom_range(0, 255));
      end
      4: begin
        l1 = 8'(p / 2 + $urandom_range(0, 1));
        l2 = 8'(l1 + $urandom_range(0, 2));
        if ($urandom_range(0, 1)) {l1, l2} = {l2, l1};
      end
      default: begin
        l1 = 8'($urandom_range(0, 3));
        l2 = 8'($urandom_range(0, 3));
      end
    endcase
  endtask

  initial begin : receiver
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [255:0] r;
    logic [255:0] s1;
    logic [255:0] s2;
    logic [7:0]   l1;
    logic [7:0]   l2;
    pair_ch.valid         <= 1'b0;
    pair_ch.seq1_word0    <= '0;
    pair_ch.seq1_word1    <= '0;
    pair_ch.seq1_word2    <= '0;
    pair_ch.seq1_word3    <= '0;
    pair_ch.seq2_word0    <= '0;
    pair_ch.seq2_word1    <= '0;
    pair_ch.seq2_word2    <= '0;
    pair_ch.seq2_word3    <= '0;
    pair_ch.first_length  <= '0;
    pair_ch.second_length <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    offer_pair('0, '0, 8'd0, 8'd0);
    sender_gap(2);
    offer_pair('0, bit_at(0), 8'd0, 8'd5);
    sender_gap(2);
    offer_pair('1, '0, 8'd0, 8'd5);
    sender_gap(2);
    offer_pair('1, '0, 8'd5, 8'd0);
    offer_pair('1, '1, 8'd128, 8'd128);
    offer_pair('1, '1, 8'd128, 8'd200);
    r = rand_seq();
    offer_pair(r, r, 8'd255, 8'd130);
    sender_gap(2);
    offer_pair('1, '0, 8'd128, 8'd128);
    offer_pair('1 ^ bit_at(255), '1, 8'd128, 8'd128);
    r = rand_seq();
    offer_pair(r, r ^ bit_at(40), 8'd10, 8'd10);
    offer_pair(r, r ^ bit_at(40), 8'd10, 8'd12);
    sender_gap(2);
    offer_pair(r | bit_at(64), r | bit_at(64), 8'd32, 8'd33);
    offer_pair(r & ~bit_at(64), r & ~bit_at(64), 8'd32, 8'd33);
    offer_pair(r | bit_at(254), r | bit_at(254), 8'd127, 8'd128);
    offer_pair(r & ~bit_at(254), r & ~bit_at(254), 8'd128, 8'd127);
    sender_gap(2);
    offer_pair(bit_at(0) | bit_at(1), bit_at(0), 8'd1, 8'd1);
    offer_pair({64'hFFFF_FFFF_FFFF_FFFF, 192'd0},
               {64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 128'd0},
               8'd64, 8'd64);
    offer_pair(rand_seq(), rand_seq(), 8'd255, 8'd255);
    offer_pair(r, r ^ bit_at(200), 8'd129, 8'd64);
    sender_gap(2);
    offer_pair(r, r ^ bit_at(63), 8'd128, 8'd128);
    offer_pair(r, r ^ bit_at(64), 8'd128, 8'd128);
    offer_pair(r, r ^ bit_at(191), 8'd96, 8'd100);
    offer_pair(r, r ^ bit_at(192), 8'd96, 8'd100);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) hold_req = 1'b1;
      if (i == 240) begin
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
      end
      if (i == RANDOM_ITEMS - 60) quiet = 1'b1;
      make_pair(s1, s2, l1, l2);
      offer_pair(s1, s2, l1, l2);
      if (i < 60 || (i >= 180 && i < 300)) sender_gap(2);
      else if (i >= 300) sender_gap(8);
    end

    pair_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
